// File: hdl/tsrbx_pkg.sv
// ----------------------------------------------------------------------------
// tsrbx_pkg
// Shared constants and types of the three-stage ring buffer with xor recode.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrbx_pkg;

	// Default sizing, handed down from the top level
	localparam int unsigned MAX_BYTES_DEF   = 4096;
	localparam int unsigned CHUNK_BYTES_DEF = 64;

	// Fixed field widths
	localparam int unsigned CFG_W      = 7;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned REL_W      = 13;
	localparam int unsigned ADDR_MAX_W = 16;    // covers the largest supported store

	// Chunk count after reset
	localparam int unsigned CHUNK_COUNT_RST = 64;

	// Operation codes on the input channel
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_XOR   = 2'd1;
	localparam logic [OP_W-1:0] OP_PASS  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	// Store access carried out by the back end
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_XOR   = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]            kind;
		logic [ADDR_MAX_W-1:0] addr;
		logic [BYTE_W-1:0]     data;
		logic                  acc;
		logic [REL_W-1:0]      released;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// File: hdl/tsrbx_queue.sv
// ----------------------------------------------------------------------------
// tsrbx_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrbx_queue
	import tsrbx_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire cmd_t   push_cmd,
	input  wire logic   pop,
	output cmd_t        head_cmd,
	output qstat_t      status
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_cmd     = ent_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/tsrbx_front.sv
// ----------------------------------------------------------------------------
// tsrbx_front
// Accepts items, checks the region counts and moves the pointers; pushes one
// command per item into the queue, with no store access for a pass or refused item.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrbx_front
	import tsrbx_pkg::*;
#(
	parameter int unsigned MAX_BYTES   = MAX_BYTES_DEF,
	parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [BYTE_W-1:0] data,
	input  wire qstat_t            q_status,
	output logic                   push,
	output cmd_t                   push_cmd
);

	localparam int unsigned PTR_W    = $clog2(MAX_BYTES);
	localparam int unsigned CNT_W    = $clog2(MAX_BYTES + 1);
	localparam int unsigned RST_PROD = CHUNK_COUNT_RST * CHUNK_BYTES;
	localparam int unsigned RST_SIZE = (RST_PROD > MAX_BYTES) ? 0 : RST_PROD;

	logic [CNT_W-1:0] size_q;
	logic [PTR_W-1:0] wr_pos_q, rc_pos_q, rd_pos_q;
	logic [CNT_W-1:0] free_q, pend_q, rdbl_q;

	logic [PTR_W-1:0] wr_pos_d, rc_pos_d, rd_pos_d;
	logic [CNT_W-1:0] free_d, pend_d, rdbl_d;

	logic [31:0]      size_prod;
	logic             size_ok;
	logic [CNT_W:0]   pass_sum;
	logic [CNT_W:0]   pass_wrap;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// Size from a new chunk count; zero when out of range
	assign size_prod = 32'(cfg_wr_data) * 32'(CHUNK_BYTES);
	assign size_ok   = (cfg_wr_data != '0) && (size_prod <= 32'(MAX_BYTES));

	// Pass: pointer plus pending stays below twice the size
	assign pass_sum  = (CNT_W+1)'(rc_pos_q) + (CNT_W+1)'(pend_q);
	assign pass_wrap = (pass_sum >= (CNT_W+1)'(size_q)) ?
	                   pass_sum - (CNT_W+1)'(size_q) : pass_sum;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
	                                             input logic [CNT_W-1:0] sz);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= sz) ? '0 : PTR_W'(n);
	endfunction

	always_comb begin
		push_cmd          = '0;
		push_cmd.kind     = CMD_NONE;
		wr_pos_d          = wr_pos_q;
		rc_pos_d          = rc_pos_q;
		rd_pos_d          = rd_pos_q;
		free_d            = free_q;
		pend_d            = pend_q;
		rdbl_d            = rdbl_q;
		case (op)
			OP_WRITE: begin
				if (free_q != '0) begin
					push_cmd.kind = CMD_WRITE;
					push_cmd.addr = ADDR_MAX_W'(wr_pos_q);
					push_cmd.data = data;
					push_cmd.acc  = 1'b1;
					wr_pos_d      = advance(wr_pos_q, size_q);
					free_d        = free_q - CNT_W'(1);
					pend_d        = pend_q + CNT_W'(1);
				end
			end
			OP_XOR: begin
				if (pend_q != '0) begin
					push_cmd.kind = CMD_XOR;
					push_cmd.addr = ADDR_MAX_W'(rc_pos_q);
					push_cmd.data = data;
					push_cmd.acc  = 1'b1;
					rc_pos_d      = advance(rc_pos_q, size_q);
					pend_d        = pend_q - CNT_W'(1);
					rdbl_d        = rdbl_q + CNT_W'(1);
				end
			end
			OP_PASS: begin
				if (pend_q != '0) begin
					push_cmd.acc      = 1'b1;
					push_cmd.released = REL_W'(pend_q);
					rc_pos_d          = PTR_W'(pass_wrap);
					rdbl_d            = rdbl_q + pend_q;
					pend_d            = '0;
				end
			end
			OP_READ: begin
				if (rdbl_q != '0) begin
					push_cmd.kind = CMD_READ;
					push_cmd.addr = ADDR_MAX_W'(rd_pos_q);
					push_cmd.acc  = 1'b1;
					rd_pos_d      = advance(rd_pos_q, size_q);
					rdbl_d        = rdbl_q - CNT_W'(1);
					free_d        = free_q + CNT_W'(1);
				end
			end
			default: begin
				push_cmd.kind = CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= CNT_W'(RST_SIZE);
			wr_pos_q <= '0;
			rc_pos_q <= '0;
			rd_pos_q <= '0;
			free_q   <= CNT_W'(RST_SIZE);
			pend_q   <= '0;
			rdbl_q   <= '0;
		end else if (cfg_wr_en) begin
			size_q   <= size_ok ? CNT_W'(size_prod) : '0;
			wr_pos_q <= '0;
			rc_pos_q <= '0;
			rd_pos_q <= '0;
			free_q   <= size_ok ? CNT_W'(size_prod) : '0;
			pend_q   <= '0;
			rdbl_q   <= '0;
		end else if (push) begin
			wr_pos_q <= wr_pos_d;
			rc_pos_q <= rc_pos_d;
			rd_pos_q <= rd_pos_d;
			free_q   <= free_d;
			pend_q   <= pend_d;
			rdbl_q   <= rdbl_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tsrbx_back.sv
// ----------------------------------------------------------------------------
// tsrbx_back
// Carries out store commands in order: byte store, one access stage and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrbx_back
	import tsrbx_pkg::*;
#(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qstat_t            q_status,
	input  wire cmd_t              q_cmd,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic [BYTE_W-1:0]      read_byte,
	output logic [REL_W-1:0]       released_count
);

	localparam int unsigned PTR_W = $clog2(MAX_BYTES);

	logic [BYTE_W-1:0] mem [MAX_BYTES];

	cmd_t              cmd_s1;
	logic              valid_s1;
	logic [BYTE_W-1:0] rdata_s1;
	logic              byp_hit_s1;
	logic [BYTE_W-1:0] byp_data_s1;

	logic              out_valid_q;
	logic              acc_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic [REL_W-1:0]  rel_q;

	logic              adv;
	logic              s1_wr;
	logic [BYTE_W-1:0] rd_eff;
	logic [BYTE_W-1:0] wdata;

	assign adv    = valid_s1 && (!out_valid_q || out_ready);
	assign q_pop  = !q_status.empty && (!valid_s1 || adv);
	assign s1_wr  = valid_s1 && ((cmd_s1.kind == CMD_WRITE) || (cmd_s1.kind == CMD_XOR));
	// store write lands at the same edge as the next read: forward it
	assign rd_eff = byp_hit_s1 ? byp_data_s1 : rdata_s1;
	assign wdata  = (cmd_s1.kind == CMD_WRITE) ? cmd_s1.data : (rd_eff ^ cmd_s1.data);

	always_ff @(posedge clk) begin
		if (adv && s1_wr) begin
			mem[cmd_s1.addr[PTR_W-1:0]] <= wdata;
		end
		if (q_pop) begin
			rdata_s1 <= mem[q_cmd.addr[PTR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1      <= q_cmd;
			byp_hit_s1  <= adv && s1_wr && (cmd_s1.addr == q_cmd.addr);
			byp_data_s1 <= wdata;
		end
		if (adv) begin
			acc_q   <= cmd_s1.acc;
			rbyte_q <= (cmd_s1.kind == CMD_READ) ? rd_eff : '0;
			rel_q   <= cmd_s1.released;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = acc_q;
	assign read_byte      = rbyte_q;
	assign released_count = rel_q;

endmodule

`default_nettype wire

// File: hdl/three_stage_ring_buffer_xor_top.sv
// ----------------------------------------------------------------------------
// three_stage_ring_buffer_xor_top
// Byte ring buffer with write, xor recode / pass and read regions.
// ----------------------------------------------------------------------------
// Path: an accepted item goes into the command queue, then through the store
//   access stage and the result register to the output.
// Throughput: 1 item per cycle without queue or output stalls; the store has
//   one write and one read port; a recode's write is forwarded to the next access.
// Reset: pointers and the pending and readable counts clear, size is 64 chunks,
//   all free; store contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module three_stage_ring_buffer_xor_top
	import tsrbx_pkg::*;
#(
	parameter int unsigned MAX_BYTES   = MAX_BYTES_DEF,
	parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: chunk count, writing it empties the buffer
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,
	// input items
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [BYTE_W-1:0] data,
	// result items
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic [BYTE_W-1:0]      read_byte,
	output logic [REL_W-1:0]       released_count
);

	// Front end owns every pointer and count, so whether an item is taken is
	// settled at the accept edge. The back end only touches the byte store,
	// in item order; the queue lets a stalled output hold up the back end
	// without stalling the front until the queue fills.
	logic   push;
	cmd_t   push_cmd;
	logic   q_pop;
	cmd_t   q_head;
	qstat_t q_status;

	tsrbx_front #(
		.MAX_BYTES   (MAX_BYTES),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.data        (data),
		.q_status    (q_status),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	tsrbx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (q_head),
		.status   (q_status)
	);

	// Store access stage plus result register
	tsrbx_back #(
		.MAX_BYTES (MAX_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.q_cmd          (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.read_byte      (read_byte),
		.released_count (released_count)
	);

	// A refused item carries no byte and no count
	a_refused_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> (read_byte == '0) && (released_count == '0))
		else $error("refused item carries a payload");

	// A pass result never carries a read byte
	a_pass_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (released_count != '0) |-> accepted && (read_byte == '0))
		else $error("pass result mixed with read byte");

	// Front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("command queue overflow");

	// Back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command queue underflow");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-stage byte ring buffer with xor recode.
// A scoreboard class mirrors the buffer pointers, counts and byte store,
// predicts one result per accepted item, and checks results in order.
// Directed items cover the empty regions, the data extremes and each
// operation. Random runs then go through several chunk counts, invalid ones
// included, under changing valid/ready pressure.
// ----------------------------------------------------------------------------

module tb_top
	import tsrbx_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no item moving
	localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned N_PHASES     = 12;

	// ------------------------------------------------------------------------
	// Scoreboard: mirror of the buffer plus the queue of results still owed
	// ------------------------------------------------------------------------
	class ring_scoreboard;
		typedef struct packed {
			logic             acc;
			logic [BYTE_W-1:0] rbyte;
			logic [REL_W-1:0]  rel;
		} result_t;

		logic [BYTE_W-1:0] mem [MAX_BYTES_DEF];
		int unsigned       size_bytes;
		int unsigned       wr_pos, rc_pos, rd_pos;
		int unsigned       n_free, n_pend, n_ready;
		result_t           owed [$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       moved [4];
		int unsigned       refused;

		function void configure(input logic [CFG_W-1:0] chunks);
			size_bytes = chunks * CHUNK_BYTES_DEF;
			if (chunks == 0 || size_bytes > MAX_BYTES_DEF)
				size_bytes = 0;
			wr_pos  = 0;
			rc_pos  = 0;
			rd_pos  = 0;
			n_free  = size_bytes;
			n_pend  = 0;
			n_ready = 0;
		endfunction

		function int unsigned wrap_next(input int unsigned pos);
			return (pos + 1 >= size_bytes) ? 0 : pos + 1;
		endfunction

		// Accepted input item: advance the mirror and queue its result
		function void note_input(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] val);
			result_t r;
			r = '0;
			case (code)
				OP_WRITE: if (n_free != 0) begin
					mem[wr_pos] = val;
					wr_pos = wrap_next(wr_pos);
					n_free--;
					n_pend++;
					r.acc = 1'b1;
				end
				OP_XOR: if (n_pend != 0) begin
					mem[rc_pos] = mem[rc_pos] ^ val;
					rc_pos = wrap_next(rc_pos);
					n_pend--;
					n_ready++;
					r.acc = 1'b1;
				end
				OP_PASS: if (n_pend != 0 && size_bytes != 0) begin
					r.rel = n_pend[REL_W-1:0];
					rc_pos = (rc_pos + n_pend) % size_bytes;
					n_ready += n_pend;
					n_pend = 0;
					r.acc = 1'b1;
				end
				OP_READ: if (n_ready != 0) begin
					r.rbyte = mem[rd_pos];
					rd_pos = wrap_next(rd_pos);
					n_ready--;
					n_free++;
					r.acc = 1'b1;
				end
				default: begin
					r = '0;
				end
			endcase
			if (r.acc)
				moved[code]++;
			else
				refused++;
			owed.push_back(r);
		endfunction

		function void check_result(input logic acc, input logic [BYTE_W-1:0] rbyte,
				input logic [REL_W-1:0] rel);
			result_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: acc=%0b read_byte=%02h released=%0d",
					$time, acc, rbyte, rel);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (acc !== want.acc) begin
				errors++;
				$display("%0t: accepted expected %0b, got %0b", $time, want.acc, acc);
			end
			if (rbyte !== want.rbyte) begin
				errors++;
				$display("%0t: read_byte expected %02h, got %02h", $time, want.rbyte, rbyte);
			end
			if (rel !== want.rel) begin
				errors++;
				$display("%0t: released_count expected %0d, got %0d", $time, want.rel, rel);
			end
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals, every input known from time zero
	// ------------------------------------------------------------------------
	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              cfg_wr_en      = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data    = '0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   op             = OP_WRITE;
	logic [BYTE_W-1:0] data           = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic              accepted;
	logic [BYTE_W-1:0] read_byte;
	logic [REL_W-1:0]  released_count;

	ring_scoreboard sb;

	// Idling controls, changed per phase by the stimulus process
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_asks      = 0;   // bumped to request a long hold-off
	int unsigned items_sent     = 0;

	// Chunk count per random phase; -1 picks a random valid count.
	// 0, 65 and 127 give a zero-size buffer where everything is refused.
	int phase_cfg [N_PHASES] = '{1, 64, 2, 0, 3, 1, 127, -1, 64, 65, 1, 4};

	three_stage_ring_buffer_xor_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.data           (data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.read_byte      (read_byte),
		.released_count (released_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sender: offer one item, with an optional idle gap first. Valid is only
	// dropped when a gap is taken, so back-to-back items keep it high.
	// ------------------------------------------------------------------------
	task automatic push_item(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] val);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op       <= code;
		data     <= val;
		do @(posedge clk); while (!in_ready);
		sb.note_input(code, val);
		items_sent++;
	endtask

	// Chunk count write: only once every owed result is back and the
	// pipeline has had time to settle.
	task automatic write_chunks(input logic [CFG_W-1:0] chunks);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= chunks;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.configure(chunks);
	endtask

	// Random traffic in runs of one operation, so the buffer actually fills,
	// recodes and drains; about a tenth of the runs are mixed noise.
	task automatic random_phase(input int unsigned count);
		int unsigned      sent;
		int unsigned      kind;
		int unsigned      run_len;
		logic [OP_W-1:0]  code;
		sent = 0;
		while (sent < count) begin
			kind    = $urandom_range(0, 9);
			run_len = (kind == 6) ? 1 : $urandom_range(1, 72);
			for (int k = 0; k < run_len && sent < count; k++) begin
				case (kind)
					0, 1, 2, 3: code = OP_WRITE;
					4, 5:       code = OP_XOR;
					6:          code = OP_PASS;
					7, 8:       code = OP_READ;
					default:    code = OP_W'($urandom_range(0, 3));
				endcase
				push_item(code, BYTE_W'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a counted hold-off when one is requested
	// ------------------------------------------------------------------------
	initial begin : receiver
		int unsigned hold_left;
		int unsigned holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_seen) begin
				holds_seen = hold_asks;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Result monitor: values read here are those from before the edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(accepted, read_byte, released_count);
		end
	end

	// Watchdog: stop if no item moves on either channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int          cfg_val;
		int unsigned n_items;
		sb = new;
		sb.configure(CFG_W'(CHUNK_COUNT_RST));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset size: all regions start empty
		push_item(OP_READ,  8'hFF);
		push_item(OP_XOR,   8'h5A);
		push_item(OP_PASS,  8'hAA);
		push_item(OP_WRITE, 8'h00);
		push_item(OP_WRITE, 8'hFF);
		push_item(OP_WRITE, 8'hA5);
		push_item(OP_WRITE, 8'h3C);
		push_item(OP_READ,  8'h00);    // nothing readable yet
		push_item(OP_XOR,   8'hFF);    // 00 becomes FF
		push_item(OP_XOR,   8'h00);    // FF stays FF
		push_item(OP_READ,  8'h00);
		push_item(OP_PASS,  8'h55);    // releases the last two unchanged
		push_item(OP_PASS,  8'h00);    // nothing left pending
		push_item(OP_XOR,   8'h81);    // nothing pending
		push_item(OP_READ,  8'h00);
		push_item(OP_READ,  8'h7E);
		push_item(OP_READ,  8'h00);
		push_item(OP_READ,  8'h00);    // empty again
		push_item(OP_WRITE, 8'h81);
		push_item(OP_WRITE, 8'h7E);
		push_item(OP_PASS,  8'hFF);
		push_item(OP_READ,  8'h00);
		push_item(OP_READ,  8'h00);
		push_item(OP_WRITE, 8'h42);    // left pending, then cleared by the write below

		for (int p = 0; p < N_PHASES; p++) begin
			cfg_val = (phase_cfg[p] < 0) ? $urandom_range(1, 64) : phase_cfg[p];
			write_chunks(cfg_val[CFG_W-1:0]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			// full-rate phases open with a long hold-off so the DUT backs up
			if (p % 4 == 0)
				hold_asks++;
			n_items = (cfg_val >= 1 && cfg_val <= 64) ? 140 : 20;
			random_phase(n_items);
		end

		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent, %0d results checked over %0d chunk-count settings",
			items_sent, sb.checked, N_PHASES + 1);
		$display("moved: %0d writes, %0d xor, %0d pass, %0d reads; %0d refused",
			sb.moved[OP_WRITE], sb.moved[OP_XOR], sb.moved[OP_PASS], sb.moved[OP_READ],
			sb.refused);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/tsrbx_pkg.sv
hdl/tsrbx_queue.sv
hdl/tsrbx_front.sv
hdl/tsrbx_back.sv
hdl/three_stage_ring_buffer_xor_top.sv
tb/tb_top.sv
